// ===== rtl/lru_key_value_cache_macros.svh =====
// Assertion macros shared by the cache RTL.
`ifndef LRU_KEY_VALUE_CACHE_MACROS_SVH
`define LRU_KEY_VALUE_CACHE_MACROS_SVH

// Check that expr is true at every clock edge outside reset.
`define LKVC_ASSERT_HOLDS(label, clk, rst, expr, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);

// Check that cons is true in the cycle after ante.
`define LKVC_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/lkvc_pkg.sv =====
`default_nettype none

package lkvc_pkg;

   localparam int ENTRIES    = 16;
   localparam int KEY_BITS   = 20;
   localparam int VALUE_BITS = 32;
   localparam int CAP_BITS   = 5;
   localparam int RANK_BITS  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam int CNT_BITS   = $clog2(ENTRIES + 1);
   localparam int CMP_BITS   = (CNT_BITS > CAP_BITS) ? CNT_BITS : CAP_BITS;

   localparam logic [CAP_BITS-1:0]          CAP_RESET  = CAP_BITS'(16);
   localparam logic signed [VALUE_BITS-1:0] MISS_VALUE = '1;

   typedef enum logic {
      CMD_GET = 1'b0,
      CMD_SET = 1'b1
   } cmd_type;

endpackage

`default_nettype wire

// ===== rtl/lru_key_value_cache.sv =====
`default_nettype none

// Fully associative key/value cache with least-recently-used replacement,
// 16 entries, 20-bit keys, 32-bit values. A request (get or set) is taken
// into a request register; from it the key is compared against all entries
// at once, the entry ranks are updated on a set or a hit and, for a get,
// the response register is loaded. One request is taken every cycle while
// no get waits in the request register; a get waits there only while an
// earlier response has not been taken. A set gives no response. Capacity
// (1 to 16, 0 acts as 1, larger values as 16) must be written only while
// the cache is idle; the block itself does not enforce this. Lowering it
// below the fill level evicts nothing until later inserts. The cache is
// empty after reset.
`include "lru_key_value_cache_macros.svh"

module lru_key_value_cache
   import lkvc_pkg::*;
(
   input  wire                            clock,
   input  wire                            reset,
   input  wire                            csr_write_enable,
   input  wire [CAP_BITS-1:0]             csr_write_data,
   input  wire                            req_valid,
   output logic                           req_ready,
   input  wire                            req_cmd,
   input  wire [KEY_BITS-1:0]             req_key,
   input  wire signed [VALUE_BITS-1:0]    req_write_value,
   output logic                           rsp_valid,
   input  wire                            rsp_ready,
   output logic                           rsp_hit,
   output logic signed [VALUE_BITS-1:0]   rsp_read_value
);

   logic [CAP_BITS-1:0]          cap_ff;
   logic                         stage_valid_ff;
   cmd_type                      stage_cmd_ff;
   logic [KEY_BITS-1:0]          stage_key_ff;
   logic signed [VALUE_BITS-1:0] stage_value_ff;
   logic                         rsp_valid_ff;
   logic                         rsp_hit_ff;
   logic signed [VALUE_BITS-1:0] rsp_value_ff;

   logic [ENTRIES-1:0]           valid_ff;
   logic [ENTRIES-1:0]           valid_in;
   logic [KEY_BITS-1:0]          key_ff   [ENTRIES];
   logic [KEY_BITS-1:0]          key_in   [ENTRIES];
   logic signed [VALUE_BITS-1:0] value_ff [ENTRIES];
   logic signed [VALUE_BITS-1:0] value_in [ENTRIES];
   logic [RANK_BITS-1:0]         rank_ff  [ENTRIES];
   logic [RANK_BITS-1:0]         rank_in  [ENTRIES];
   logic [CNT_BITS-1:0]          cnt_ff;
   logic [CNT_BITS-1:0]          cnt_in;

   logic                         out_free;
   logic                         stage_fire;
   logic                         is_set;
   logic [ENTRIES-1:0]           hit_vec;
   logic                         any_hit;
   logic [RANK_BITS-1:0]         hit_rank;
   logic signed [VALUE_BITS-1:0] hit_value;
   logic [CMP_BITS-1:0]          cap_ext;
   logic [CMP_BITS-1:0]          eff_cap;
   logic                         full;
   logic [CNT_BITS-1:0]          cnt_minus_one;
   logic [ENTRIES-1:0]           victim_vec;
   logic [ENTRIES-1:0]           free_vec;
   logic [ENTRIES-1:0]           free_onehot;
   logic [ENTRIES-1:0]           sel_vec;
   logic [CNT_BITS-1:0]          old_rank;
   logic                         do_update;

   assign out_free   = !rsp_valid_ff || rsp_ready;
   assign is_set     = (stage_cmd_ff == CMD_SET);
   assign stage_fire = stage_valid_ff && (is_set || out_free);
   assign req_ready  = !stage_valid_ff || stage_fire;

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_hit        = rsp_hit_ff;
   assign rsp_read_value = rsp_value_ff;

   // lookup
   always_comb begin
      hit_rank  = '0;
      hit_value = '0;
      for (int i = 0; i < ENTRIES; i++) begin
         hit_vec[i] = valid_ff[i] && (key_ff[i] == stage_key_ff);
         if (hit_vec[i]) begin
            hit_rank  = hit_rank | rank_ff[i];
            hit_value = hit_value | value_ff[i];
         end
      end
      any_hit = |hit_vec;
   end

   // capacity and slot choice
   always_comb begin
      cap_ext = CMP_BITS'(cap_ff);
      if (cap_ext == '0) begin
         eff_cap = CMP_BITS'(1);
      end else if (cap_ext > CMP_BITS'(ENTRIES)) begin
         eff_cap = CMP_BITS'(ENTRIES);
      end else begin
         eff_cap = cap_ext;
      end
      full          = (CMP_BITS'(cnt_ff) >= eff_cap);
      cnt_minus_one = cnt_ff - CNT_BITS'(1);
      for (int i = 0; i < ENTRIES; i++) begin
         victim_vec[i] = valid_ff[i] && (rank_ff[i] == cnt_minus_one[RANK_BITS-1:0]);
      end
      free_vec    = ~valid_ff;
      free_onehot = free_vec & (~free_vec + ENTRIES'(1));
      if (any_hit) begin
         sel_vec  = hit_vec;
         old_rank = CNT_BITS'(hit_rank);
      end else if (full) begin
         sel_vec  = victim_vec;
         old_rank = cnt_minus_one;
      end else begin
         sel_vec  = free_onehot;
         old_rank = cnt_ff;
      end
      do_update = stage_fire && (is_set || any_hit);
   end

   // next entry state
   always_comb begin
      valid_in = valid_ff;
      cnt_in   = cnt_ff;
      for (int i = 0; i < ENTRIES; i++) begin
         key_in[i]   = key_ff[i];
         value_in[i] = value_ff[i];
         rank_in[i]  = rank_ff[i];
         if (do_update) begin
            if (sel_vec[i]) begin
               rank_in[i] = '0;
            end else if (valid_ff[i] && (CNT_BITS'(rank_ff[i]) < old_rank)) begin
               rank_in[i] = rank_ff[i] + RANK_BITS'(1);
            end
         end
         if (stage_fire && is_set && sel_vec[i]) begin
            valid_in[i] = 1'b1;
            key_in[i]   = stage_key_ff;
            value_in[i] = stage_value_ff;
         end
      end
      if (stage_fire && is_set && !any_hit && !full) begin
         cnt_in = cnt_ff + CNT_BITS'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cap_ff         <= CAP_RESET;
         stage_valid_ff <= 1'b0;
         rsp_valid_ff   <= 1'b0;
         valid_ff       <= '0;
         cnt_ff         <= '0;
         for (int i = 0; i < ENTRIES; i++) begin
            rank_ff[i] <= '0;
         end
      end else begin
         if (csr_write_enable) begin
            cap_ff <= csr_write_data;
         end
         if (req_ready) begin
            stage_valid_ff <= req_valid;
         end
         if (stage_fire && !is_set) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         valid_ff <= valid_in;
         cnt_ff   <= cnt_in;
         for (int i = 0; i < ENTRIES; i++) begin
            rank_ff[i] <= rank_in[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         stage_cmd_ff   <= cmd_type'(req_cmd);
         stage_key_ff   <= req_key;
         stage_value_ff <= req_write_value;
      end
      if (stage_fire && !is_set) begin
         rsp_hit_ff   <= any_hit;
         rsp_value_ff <= any_hit ? hit_value : MISS_VALUE;
      end
      for (int i = 0; i < ENTRIES; i++) begin
         key_ff[i]   <= key_in[i];
         value_ff[i] <= value_in[i];
      end
   end

   `LKVC_ASSERT_HOLDS(a_count_matches_valid, clock, reset, $countones(valid_ff) == cnt_ff, "entry count differs from valid entries")
   `LKVC_ASSERT_HOLDS(a_count_in_range, clock, reset, cnt_ff <= CNT_BITS'(ENTRIES), "entry count above depth")
   `LKVC_ASSERT_NEXT(a_get_responds, clock, reset, stage_fire && !is_set, rsp_valid_ff, "get transfer gave no response")
   `LKVC_ASSERT_NEXT(a_set_silent, clock, reset, stage_fire && is_set && !rsp_valid_ff, !rsp_valid_ff, "set produced a response")
   `LKVC_ASSERT_HOLDS(a_single_hit, clock, reset, $onehot0(hit_vec), "key present in more than one entry")

endmodule

`default_nettype wire
